// ===== rtl/core/qrs_pkg.sv =====
`timescale 1ns / 1ps

package qrs_pkg;

	localparam int QRS_WORD_BITS = 32;
	localparam int QRS_FRAC_BITS = 16;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ONE  = 2'd1;
	localparam logic [1:0] KIND_TWO  = 2'd2;
	localparam logic [1:0] KIND_ANY  = 2'd3;

	// control that rides along with each coefficient set
	typedef struct packed {
		logic       vld;
		logic       quad;
		logic [1:0] kind;
		logic       lo_use;
		logic       hi_use;
		logic       lo_neg;
		logic       hi_neg;
	} qrs_meta_t;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
`timescale 1ns / 1ps

// channel   ports                                       transfer
// ------    ------------------------------------------  -----------------------
// input     start, busy, coef_a, coef_b, coef_c         start && !busy
// result    done, root_kind, root_low, root_high,       done (one cycle)
//           saturated
//
// One coefficient set may be taken every cycle; busy stays low.
// The pipeline holds three front stages, WORD_BITS+1 square root cells,
// one sum stage, WORD_BITS+FRAC_BITS+2 divider cells and the output register.
// arst_n clears every valid flag in the chain; payload is not reset.
// The receiver cannot stall; each result shows for one cycle only.

module quadratic_root_solver #(
	parameter int WORD_BITS = qrs_pkg::QRS_WORD_BITS,
	parameter int FRAC_BITS = qrs_pkg::QRS_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_BITS-1:0] coef_a,
	input  logic signed [WORD_BITS-1:0] coef_b,
	input  logic signed [WORD_BITS-1:0] coef_c,
	output logic                        done,
	output logic [1:0]                  root_kind,
	output logic signed [WORD_BITS-1:0] root_low,
	output logic signed [WORD_BITS-1:0] root_high,
	output logic                        saturated
);

	localparam int W   = WORD_BITS;
	localparam int RW  = W + 1;
	localparam int XW  = 2 * RW;
	localparam int RMW = RW + 2;
	localparam int CW  = 3 * W + 2;
	localparam int SW  = W + 2;
	localparam int NW  = SW + FRAC_BITS;
	localparam int DV  = W + 1;

	// front stages
	qrs_pkg::qrs_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [W-1:0]       am_s1, bm_s1, cm_s1, am_s2, bm_s2, cm_s2;
	logic               an_s1, bn_s1, cn_s1, an_s2, bn_s2, cn_s2;
	logic [2*W-1:0]     bb_s2, ac_s2;
	logic [XW-1:0]      d_s3;
	logic [CW-1:0]      carry_s3;

	logic               an_in, bn_in, cn_in;
	logic [W-1:0]       am_in, bm_in, cm_in;
	qrs_pkg::qrs_meta_t meta_in;

	assign busy  = 1'b0;
	assign an_in = coef_a[W-1];
	assign bn_in = coef_b[W-1];
	assign cn_in = coef_c[W-1];
	assign am_in = an_in ? (~coef_a + 1'b1) : coef_a;
	assign bm_in = bn_in ? (~coef_b + 1'b1) : coef_b;
	assign cm_in = cn_in ? (~coef_c + 1'b1) : coef_c;

	always_comb begin
		meta_in        = '0;
		meta_in.vld    = start & ~busy;
		meta_in.kind   = qrs_pkg::KIND_NONE;
		if (am_in != '0) begin
			meta_in.quad = 1'b1;
		end else if (bm_in == '0) begin
			meta_in.kind = (cm_in == '0) ? qrs_pkg::KIND_ANY : qrs_pkg::KIND_NONE;
		end else begin
			meta_in.kind   = qrs_pkg::KIND_ONE;
			meta_in.lo_use = 1'b1;
			meta_in.lo_neg = (cn_in == bn_in);
		end
	end

	logic [XW-1:0]      bb_x, ac4_x, d_x;
	logic               d_ok;
	qrs_pkg::qrs_meta_t meta_d;

	assign bb_x  = XW'(bb_s2);
	assign ac4_x = {ac_s2, 2'b00};

	always_comb begin
		meta_d = meta_s2;
		d_ok   = 1'b1;
		d_x    = bb_x + ac4_x;
		if (an_s2 == cn_s2) begin
			d_ok = (bb_x >= ac4_x);
			d_x  = bb_x - ac4_x;
		end
		if (meta_s2.quad) begin
			if (d_ok) begin
				meta_d.kind   = (d_x == '0) ? qrs_pkg::KIND_ONE : qrs_pkg::KIND_TWO;
				meta_d.lo_use = 1'b1;
				meta_d.hi_use = 1'b1;
			end else begin
				meta_d.kind = qrs_pkg::KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_d;
		end
	end

	always_ff @(posedge clk) begin
		am_s1    <= am_in;
		bm_s1    <= bm_in;
		cm_s1    <= cm_in;
		an_s1    <= an_in;
		bn_s1    <= bn_in;
		cn_s1    <= cn_in;
		bb_s2    <= bm_s1 * bm_s1;
		ac_s2    <= am_s1 * cm_s1;
		am_s2    <= am_s1;
		bm_s2    <= bm_s1;
		cm_s2    <= cm_s1;
		an_s2    <= an_s1;
		bn_s2    <= bn_s1;
		cn_s2    <= cn_s1;
		d_s3     <= d_x;
		carry_s3 <= {am_s2, bm_s2, cm_s2, an_s2, bn_s2};
	end

	// square root chain
	qrs_pkg::qrs_meta_t sq_meta  [0:RW];
	logic [RMW-1:0]     sq_rem   [0:RW];
	logic [RW-1:0]      sq_root  [0:RW];
	logic [XW-1:0]      sq_x     [0:RW];
	logic [CW-1:0]      sq_carry [0:RW];

	assign sq_meta[0]  = meta_s3;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_x[0]     = d_s3;
	assign sq_carry[0] = carry_s3;

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		qrs_sqrt_cell #(
			.RW(RW),
			.CW(CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.meta_in  (sq_meta[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.x_in     (sq_x[i]),
			.carry_in (sq_carry[i]),
			.meta_out (sq_meta[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.x_out    (sq_x[i+1]),
			.carry_out(sq_carry[i+1])
		);
	end

	// signed sums -b-s and -b+s, and divider operands
	logic [W-1:0]       am_q, bm_q, cm_q;
	logic               an_q, bn_q;
	logic [SW-1:0]      bz, sz, lo_sm, hi_sm;
	logic               lo_sn, hi_sn;
	qrs_pkg::qrs_meta_t meta_sum;
	logic [NW-1:0]      lo_n_x, hi_n_x, lo_n_s4, hi_n_s4;
	logic [DV-1:0]      lo_d_x, hi_d_x, lo_d_s4, hi_d_s4;

	assign {am_q, bm_q, cm_q, an_q, bn_q} = sq_carry[RW];
	assign bz = SW'(bm_q);
	assign sz = SW'(sq_root[RW]);

	always_comb begin
		// low root: (!bn, b) + (neg, s)
		if (!bn_q) begin
			lo_sn = 1'b1;
			lo_sm = bz + sz;
		end else if (bz >= sz) begin
			lo_sn = 1'b0;
			lo_sm = bz - sz;
		end else begin
			lo_sn = 1'b1;
			lo_sm = sz - bz;
		end
		// high root: (!bn, b) + (pos, s)
		if (bn_q) begin
			hi_sn = 1'b0;
			hi_sm = bz + sz;
		end else if (bz >= sz) begin
			hi_sn = 1'b1;
			hi_sm = bz - sz;
		end else begin
			hi_sn = 1'b0;
			hi_sm = sz - bz;
		end
		meta_sum = sq_meta[RW];
		hi_n_x   = NW'(hi_sm) << FRAC_BITS;
		hi_d_x   = {am_q, 1'b0};
		if (meta_sum.quad) begin
			meta_sum.lo_neg = lo_sn ^ an_q;
			meta_sum.hi_neg = hi_sn ^ an_q;
			lo_n_x          = NW'(lo_sm) << FRAC_BITS;
			lo_d_x          = {am_q, 1'b0};
		end else begin
			lo_n_x = NW'(cm_q) << FRAC_BITS;
			lo_d_x = DV'(bm_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s4 <= '0;
		end else begin
			meta_s4 <= meta_sum;
		end
	end

	always_ff @(posedge clk) begin
		lo_n_s4 <= lo_n_x;
		lo_d_s4 <= lo_d_x;
		hi_n_s4 <= hi_n_x;
		hi_d_s4 <= hi_d_x;
	end

	// divider chain, both roots side by side
	qrs_pkg::qrs_meta_t dv_meta   [0:NW];
	logic [NW-1:0]      dv_lo_n   [0:NW];
	logic [DV-1:0]      dv_lo_d   [0:NW];
	logic [DV:0]        dv_lo_rem [0:NW];
	logic [NW-1:0]      dv_lo_q   [0:NW];
	logic [NW-1:0]      dv_hi_n   [0:NW];
	logic [DV-1:0]      dv_hi_d   [0:NW];
	logic [DV:0]        dv_hi_rem [0:NW];
	logic [NW-1:0]      dv_hi_q   [0:NW];

	assign dv_meta[0]   = meta_s4;
	assign dv_lo_n[0]   = lo_n_s4;
	assign dv_lo_d[0]   = lo_d_s4;
	assign dv_lo_rem[0] = '0;
	assign dv_lo_q[0]   = '0;
	assign dv_hi_n[0]   = hi_n_s4;
	assign dv_hi_d[0]   = hi_d_s4;
	assign dv_hi_rem[0] = '0;
	assign dv_hi_q[0]   = '0;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(
			.NW(NW),
			.DV(DV)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.meta_in   (dv_meta[j]),
			.lo_n_in   (dv_lo_n[j]),
			.lo_d_in   (dv_lo_d[j]),
			.lo_rem_in (dv_lo_rem[j]),
			.lo_q_in   (dv_lo_q[j]),
			.hi_n_in   (dv_hi_n[j]),
			.hi_d_in   (dv_hi_d[j]),
			.hi_rem_in (dv_hi_rem[j]),
			.hi_q_in   (dv_hi_q[j]),
			.meta_out  (dv_meta[j+1]),
			.lo_n_out  (dv_lo_n[j+1]),
			.lo_d_out  (dv_lo_d[j+1]),
			.lo_rem_out(dv_lo_rem[j+1]),
			.lo_q_out  (dv_lo_q[j+1]),
			.hi_n_out  (dv_hi_n[j+1]),
			.hi_d_out  (dv_hi_d[j+1]),
			.hi_rem_out(dv_hi_rem[j+1]),
			.hi_q_out  (dv_hi_q[j+1])
		);
	end

	// clamp and sign
	localparam logic [NW-1:0] LIM_POS = (NW'(1) << (W - 1)) - NW'(1);
	localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);

	qrs_pkg::qrs_meta_t meta_fin;
	logic [NW-1:0]      lo_lim, hi_lim, lo_mag, hi_mag;
	logic               lo_sat, hi_sat;
	logic [W-1:0]       lo_word, hi_word;

	assign meta_fin = dv_meta[NW];
	assign lo_lim   = meta_fin.lo_neg ? LIM_NEG : LIM_POS;
	assign hi_lim   = meta_fin.hi_neg ? LIM_NEG : LIM_POS;
	assign lo_sat   = meta_fin.lo_use && (dv_lo_q[NW] > lo_lim);
	assign hi_sat   = meta_fin.hi_use && (dv_hi_q[NW] > hi_lim);
	assign lo_mag   = lo_sat ? lo_lim : dv_lo_q[NW];
	assign hi_mag   = hi_sat ? hi_lim : dv_hi_q[NW];

	always_comb begin
		lo_word = '0;
		hi_word = '0;
		if (meta_fin.lo_use) begin
			lo_word = meta_fin.lo_neg ? (~lo_mag[W-1:0] + 1'b1) : lo_mag[W-1:0];
		end
		if (meta_fin.hi_use) begin
			hi_word = meta_fin.hi_neg ? (~hi_mag[W-1:0] + 1'b1) : hi_mag[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s5 <= '0;
		end else begin
			meta_s5 <= meta_fin;
		end
	end

	always_ff @(posedge clk) begin
		root_kind <= meta_fin.kind;
		root_low  <= lo_word;
		root_high <= hi_word;
		saturated <= lo_sat | hi_sat;
	end

	assign done = meta_s5.vld;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (root_kind == qrs_pkg::KIND_NONE || root_kind == qrs_pkg::KIND_ANY)
		|-> (root_low == '0) && (root_high == '0) && !saturated)
		else $error("root words not cleared for a result without roots");

	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == qrs_pkg::KIND_ONE && meta_s5.quad |-> root_low == root_high)
		else $error("double root differs between the two root words");

	a_linear_high: assert property (@(posedge clk) disable iff (!arst_n)
		done && !meta_s5.quad |-> root_high == '0)
		else $error("high root set for a linear equation");

	a_sat_use: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s5.vld && saturated |-> meta_s5.lo_use)
		else $error("clamp flagged with no root computed");

endmodule

// ===== rtl/core/qrs_sqrt_cell.sv =====
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
	parameter int RW = 33,
	parameter int CW = 98
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qrs_pkg::qrs_meta_t  meta_in,
	input  logic [RW+1:0]       rem_in,
	input  logic [RW-1:0]       root_in,
	input  logic [2*RW-1:0]     x_in,
	input  logic [CW-1:0]       carry_in,
	output qrs_pkg::qrs_meta_t  meta_out,
	output logic [RW+1:0]       rem_out,
	output logic [RW-1:0]       root_out,
	output logic [2*RW-1:0]     x_out,
	output logic [CW-1:0]       carry_out
);

	localparam int XW  = 2 * RW;
	localparam int RMW = RW + 2;

	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic           ge;

	assign rem_sh = {rem_in[RMW-3:0], x_in[XW-1:XW-2]};
	assign trial  = {root_in, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_out <= '0;
		end else begin
			meta_out <= meta_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out   <= ge ? (rem_sh - trial) : rem_sh;
		root_out  <= {root_in[RW-2:0], ge};
		x_out     <= {x_in[XW-3:0], 2'b00};
		carry_out <= carry_in;
	end

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
`timescale 1ns / 1ps

module qrs_div_cell #(
	parameter int NW = 50,
	parameter int DV = 33
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qrs_pkg::qrs_meta_t  meta_in,
	input  logic [NW-1:0]       lo_n_in,
	input  logic [DV-1:0]       lo_d_in,
	input  logic [DV:0]         lo_rem_in,
	input  logic [NW-1:0]       lo_q_in,
	input  logic [NW-1:0]       hi_n_in,
	input  logic [DV-1:0]       hi_d_in,
	input  logic [DV:0]         hi_rem_in,
	input  logic [NW-1:0]       hi_q_in,
	output qrs_pkg::qrs_meta_t  meta_out,
	output logic [NW-1:0]       lo_n_out,
	output logic [DV-1:0]       lo_d_out,
	output logic [DV:0]         lo_rem_out,
	output logic [NW-1:0]       lo_q_out,
	output logic [NW-1:0]       hi_n_out,
	output logic [DV-1:0]       hi_d_out,
	output logic [DV:0]         hi_rem_out,
	output logic [NW-1:0]       hi_q_out
);

	logic [DV:0] lo_sh;
	logic [DV:0] hi_sh;
	logic        lo_ge;
	logic        hi_ge;

	assign lo_sh = {lo_rem_in[DV-1:0], lo_n_in[NW-1]};
	assign hi_sh = {hi_rem_in[DV-1:0], hi_n_in[NW-1]};
	assign lo_ge = (lo_sh >= {1'b0, lo_d_in});
	assign hi_ge = (hi_sh >= {1'b0, hi_d_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_out <= '0;
		end else begin
			meta_out <= meta_in;
		end
	end

	always_ff @(posedge clk) begin
		lo_rem_out <= lo_ge ? (lo_sh - {1'b0, lo_d_in}) : lo_sh;
		lo_q_out   <= {lo_q_in[NW-2:0], lo_ge};
		lo_n_out   <= {lo_n_in[NW-2:0], 1'b0};
		lo_d_out   <= lo_d_in;
		hi_rem_out <= hi_ge ? (hi_sh - {1'b0, hi_d_in}) : hi_sh;
		hi_q_out   <= {hi_q_in[NW-2:0], hi_ge};
		hi_n_out   <= {hi_n_in[NW-2:0], 1'b0};
		hi_d_out   <= hi_d_in;
	end

endmodule
